/* src/stochastic_fire_spread_grid_macros.svh */
// Assertion macros shared by the fire spread grid RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef STOCHASTIC_FIRE_SPREAD_GRID_MACROS_SVH
`define STOCHASTIC_FIRE_SPREAD_GRID_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sfg_pkg.sv */
// Shared types and constants of the fire spread grid.
// No dependencies; every other source file but the assertion macro header refers to this package.
`timescale 1ns / 1ps

package sfg_pkg;

    localparam int GRID_W_DEF  = 32;
    localparam int GRID_H_DEF  = 32;

    localparam int TILE_W      = 3;
    localparam int COORD_W     = 5;
    localparam int OPCODE_W    = 2;
    localparam int CHANCE_W    = 32;
    localparam int RADIUS_W    = 4;
    localparam int NEAR_W      = 4;
    localparam int EMBER_W     = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int NEAR_PROD_W  = CHANCE_W + NEAR_W;
    localparam int EMBER_PROD_W = CHANCE_W + EMBER_W;

    localparam logic [TILE_W-1:0] TILE_FIRE = 3'd4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SNAP   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_CHANCE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMBER_CHANCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMBER_RADIUS = 2'd2;

    localparam logic [CHANCE_W-1:0] NEAR_CHANCE_RST  = 32'd42949673;
    localparam logic [CHANCE_W-1:0] EMBER_CHANCE_RST = 32'd42950;
    localparam logic [RADIUS_W-1:0] EMBER_RADIUS_RST = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SNAP,
        ST_SNAP_END,
        ST_LOOK_REQ,
        ST_LOOK,
        ST_SCAN,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TILE_W-1:0]  tile_out;
        logic [NEAR_W-1:0]  near_count;
        logic [EMBER_W-1:0] ember_count;
        logic               ignited;
    } result_t;

    typedef struct packed {
        logic active;
        logic done;
    } scan_stat_t;

endpackage

/* src/sfg_if.sv */
// Valid/ready channel interfaces for the fire spread grid item and result streams.
// Depends on sfg_pkg for the field widths.
`timescale 1ns / 1ps

interface sfg_item_if;
    logic                             valid;
    logic                             ready;
    logic [sfg_pkg::OPCODE_W-1:0]     opcode;
    logic [sfg_pkg::COORD_W-1:0]      cell_x;
    logic [sfg_pkg::COORD_W-1:0]      cell_y;
    logic [sfg_pkg::TILE_W-1:0]       tile_in;
    logic [sfg_pkg::CHANCE_W-1:0]     rand_near;
    logic [sfg_pkg::CHANCE_W-1:0]     rand_ember;

    modport source (output valid, opcode, cell_x, cell_y, tile_in, rand_near, rand_ember,
                    input ready);
    modport sink   (input valid, opcode, cell_x, cell_y, tile_in, rand_near, rand_ember,
                    output ready);
endinterface

interface sfg_result_if;
    logic                             valid;
    logic                             ready;
    logic [sfg_pkg::TILE_W-1:0]       tile_out;
    logic [sfg_pkg::NEAR_W-1:0]       near_count;
    logic [sfg_pkg::EMBER_W-1:0]      ember_count;
    logic                             ignited;

    modport source (output valid, tile_out, near_count, ember_count, ignited, input ready);
    modport sink   (input valid, tile_out, near_count, ember_count, ignited, output ready);
endinterface

/* src/sfg_mem.sv */
// Synchronous tile memory: one write port and one read port with registered read data.
// Depends on sfg_pkg for the tile width.
`timescale 1ns / 1ps

module sfg_mem #(
    parameter int DEPTH = sfg_pkg::GRID_W_DEF * sfg_pkg::GRID_H_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [sfg_pkg::TILE_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [sfg_pkg::TILE_W-1:0] rd_data
);

    logic [sfg_pkg::TILE_W-1:0] ram [DEPTH];
    logic [sfg_pkg::TILE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sfg_scan.sv */
// Window walker: issues one snapshot read per cycle over the clipped ember window
// and counts burning cells in the 3x3 and ember windows. Depends on sfg_pkg.
`timescale 1ns / 1ps

module sfg_scan #(
    parameter int GRID_W = sfg_pkg::GRID_W_DEF,
    parameter int GRID_H = sfg_pkg::GRID_H_DEF,
    localparam int XAW   = $clog2(GRID_W),
    localparam int YAW   = $clog2(GRID_H),
    localparam int AW    = $clog2(GRID_W * GRID_H)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sfg_pkg::COORD_W-1:0]  cx,
    input  logic [sfg_pkg::COORD_W-1:0]  cy,
    input  logic [sfg_pkg::RADIUS_W-1:0] radius,
    input  logic [sfg_pkg::TILE_W-1:0]   prev_data,
    output sfg_pkg::scan_stat_t          stat,
    output logic [AW-1:0]                addr,
    output logic [sfg_pkg::NEAR_W-1:0]   near_count,
    output logic [sfg_pkg::EMBER_W-1:0]  ember_count
);

    logic                         active_reg, active_next;
    logic                         tag_valid_reg;
    logic                         done_reg;
    logic [XAW-1:0]               sx_reg, xlo_reg, xhi_reg;
    logic [YAW-1:0]               sy_reg, yhi_reg;
    logic [sfg_pkg::COORD_W-1:0]  cx_reg, cy_reg;
    logic                         ember_on_reg;
    logic                         tag_last_reg, tag_center_reg, tag_near_reg;
    logic [sfg_pkg::NEAR_W-1:0]   near_reg;
    logic [sfg_pkg::EMBER_W-1:0]  ember_reg;

    logic [XAW-1:0] x_lo, x_hi;
    logic [YAW-1:0] y_lo, y_hi;
    logic           last, near_hit, center_hit;

    // Window bounds at start; a zero radius still walks the 3x3 neighborhood.
    always_comb
    begin
        int reach;
        int xl, xh, yl, yh;
        reach = (radius == '0) ? 1 : int'(radius);
        xl = int'(cx) - reach;
        xh = int'(cx) + reach;
        yl = int'(cy) - reach;
        yh = int'(cy) + reach;
        if (xl < 0)
        begin
            xl = 0;
        end
        if (yl < 0)
        begin
            yl = 0;
        end
        if (xh > GRID_W - 1)
        begin
            xh = GRID_W - 1;
        end
        if (yh > GRID_H - 1)
        begin
            yh = GRID_H - 1;
        end
        x_lo = XAW'(xl);
        x_hi = XAW'(xh);
        y_lo = YAW'(yl);
        y_hi = YAW'(yh);
    end

    always_comb
    begin
        int dx, dy;
        dx = int'(sx_reg) - int'(cx_reg);
        dy = int'(sy_reg) - int'(cy_reg);
        near_hit   = (dx >= -1) && (dx <= 1) && (dy >= -1) && (dy <= 1);
        center_hit = (dx == 0) && (dy == 0);
    end

    assign last = (sx_reg == xhi_reg) && (sy_reg == yhi_reg);
    assign addr = AW'(int'(sy_reg) * GRID_W + int'(sx_reg));

    always_comb
    begin
        active_next = active_reg;
        if (start)
        begin
            active_next = 1'b1;
        end
        else if (active_reg && last)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            tag_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            tag_valid_reg <= active_reg;
            done_reg      <= tag_valid_reg && tag_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_last_reg   <= last;
        tag_center_reg <= center_hit;
        tag_near_reg   <= near_hit;
        if (start)
        begin
            sx_reg       <= x_lo;
            sy_reg       <= y_lo;
            xlo_reg      <= x_lo;
            xhi_reg      <= x_hi;
            yhi_reg      <= y_hi;
            cx_reg       <= cx;
            cy_reg       <= cy;
            ember_on_reg <= (radius != '0);
            near_reg     <= '0;
            ember_reg    <= '0;
        end
        else
        begin
            if (active_reg)
            begin
                if (sx_reg == xhi_reg)
                begin
                    sx_reg <= xlo_reg;
                    sy_reg <= sy_reg + 1'b1;
                end
                else
                begin
                    sx_reg <= sx_reg + 1'b1;
                end
            end
            // Read data arrives in the cycle after its address; the tags travel alongside.
            if (tag_valid_reg && !tag_center_reg && (prev_data == sfg_pkg::TILE_FIRE))
            begin
                near_reg  <= near_reg + sfg_pkg::NEAR_W'(tag_near_reg);
                ember_reg <= ember_reg + sfg_pkg::EMBER_W'(ember_on_reg);
            end
        end
    end

    assign stat.active  = active_reg;
    assign stat.done    = done_reg;
    assign near_count   = near_reg;
    assign ember_count  = ember_reg;

endmodule

/* src/sfg_ctrl.sv */
// Sequencer of the fire spread grid: holds both grid memories, runs the snapshot sweep,
// the cell lookup, the window scan and the ignition test. Depends on sfg_pkg, sfg_if,
// sfg_mem and sfg_scan.
`timescale 1ns / 1ps

module sfg_ctrl #(
    parameter int GRID_W = sfg_pkg::GRID_W_DEF,
    parameter int GRID_H = sfg_pkg::GRID_H_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    sfg_item_if.sink                     item,
    input  logic [sfg_pkg::CHANCE_W-1:0] near_chance,
    input  logic [sfg_pkg::CHANCE_W-1:0] ember_chance,
    input  logic [sfg_pkg::RADIUS_W-1:0] ember_radius,
    output logic                         res_valid,
    input  logic                         res_ready,
    output sfg_pkg::result_t             res
);

    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);

    sfg_pkg::state_t state_reg, state_next;

    sfg_pkg::op_t                    op_reg;
    logic [sfg_pkg::COORD_W-1:0]     x_reg, y_reg;
    logic [sfg_pkg::TILE_W-1:0]      tile_reg;
    logic [sfg_pkg::CHANCE_W-1:0]    rn_reg, re_reg;
    logic [AW-1:0]                   snap_cnt_reg;
    logic                            snap_wr_valid_reg;
    logic [AW-1:0]                   snap_wr_addr_reg;
    logic [sfg_pkg::TILE_W-1:0]      cur_tile_reg;
    logic [sfg_pkg::TILE_W-1:0]      res_tile_reg;
    logic [sfg_pkg::NEAR_W-1:0]      res_near_reg;
    logic [sfg_pkg::EMBER_W-1:0]     res_ember_reg;
    logic                            res_ign_reg;
    logic [sfg_pkg::NEAR_PROD_W-1:0]  near_prod_reg;
    logic [sfg_pkg::EMBER_PROD_W-1:0] ember_prod_reg;

    logic                        accept;
    logic                        in_grid;
    logic [AW-1:0]               idx;
    logic                        cur_we;
    logic [sfg_pkg::TILE_W-1:0]  cur_wdata;
    logic [AW-1:0]               cur_rd_addr, prev_rd_addr;
    logic [sfg_pkg::TILE_W-1:0]  cur_rd_data, prev_rd_data;
    logic [sfg_pkg::TILE_W-1:0]  look_tile;
    logic                        scan_start;
    logic                        ignite;

    sfg_pkg::scan_stat_t         scan_stat;
    logic [AW-1:0]               scan_addr;
    logic [sfg_pkg::NEAR_W-1:0]  scan_near;
    logic [sfg_pkg::EMBER_W-1:0] scan_ember;

    assign item.ready = (state_reg == sfg_pkg::ST_IDLE);
    assign accept     = item.valid && item.ready;

    assign in_grid = (int'(x_reg) < GRID_W) && (int'(y_reg) < GRID_H);
    assign idx     = in_grid ? AW'(int'(y_reg) * GRID_W + int'(x_reg)) : '0;

    assign cur_rd_addr  = (state_reg == sfg_pkg::ST_SNAP) ? snap_cnt_reg : idx;
    assign prev_rd_addr = scan_stat.active ? scan_addr : idx;

    assign ignite = ({{sfg_pkg::NEAR_W{1'b0}}, rn_reg} < near_prod_reg) ||
                    ({{sfg_pkg::EMBER_W{1'b0}}, re_reg} < ember_prod_reg);

    sfg_mem #(
        .DEPTH   (CELLS)
    ) u_cur_mem (
        .clk     (clk),
        .wr_en   (cur_we),
        .wr_addr (idx),
        .wr_data (cur_wdata),
        .rd_addr (cur_rd_addr),
        .rd_data (cur_rd_data)
    );

    // The snapshot copy writes each cell in the cycle after its current-grid read.
    sfg_mem #(
        .DEPTH   (CELLS)
    ) u_prev_mem (
        .clk     (clk),
        .wr_en   (snap_wr_valid_reg),
        .wr_addr (snap_wr_addr_reg),
        .wr_data (cur_rd_data),
        .rd_addr (prev_rd_addr),
        .rd_data (prev_rd_data)
    );

    sfg_scan #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .cx          (x_reg),
        .cy          (y_reg),
        .radius      (ember_radius),
        .prev_data   (prev_rd_data),
        .stat        (scan_stat),
        .addr        (scan_addr),
        .near_count  (scan_near),
        .ember_count (scan_ember)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= sfg_pkg::ST_IDLE;
            snap_wr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            snap_wr_valid_reg <= (state_reg == sfg_pkg::ST_SNAP);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_we     = 1'b0;
        cur_wdata  = tile_reg;
        scan_start = 1'b0;
        res_valid  = 1'b0;
        look_tile  = cur_rd_data;
        unique case (state_reg)
            sfg_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (sfg_pkg::op_t'(item.opcode) == sfg_pkg::OP_SNAP)
                    begin
                        state_next = sfg_pkg::ST_SNAP;
                    end
                    else
                    begin
                        state_next = sfg_pkg::ST_LOOK_REQ;
                    end
                end
            end
            sfg_pkg::ST_SNAP:
            begin
                if (snap_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = sfg_pkg::ST_SNAP_END;
                end
            end
            sfg_pkg::ST_SNAP_END:
            begin
                state_next = sfg_pkg::ST_LOOK_REQ;
            end
            sfg_pkg::ST_LOOK_REQ:
            begin
                state_next = sfg_pkg::ST_LOOK;
            end
            sfg_pkg::ST_LOOK:
            begin
                state_next = sfg_pkg::ST_DONE;
                if (!in_grid)
                begin
                    look_tile = '0;
                end
                else
                begin
                    case (op_reg)
                        sfg_pkg::OP_WRITE:
                        begin
                            // Tile codes above fire are dropped and the cell keeps its tile.
                            if (tile_reg <= sfg_pkg::TILE_FIRE)
                            begin
                                cur_we    = 1'b1;
                                look_tile = tile_reg;
                            end
                        end
                        sfg_pkg::OP_UPDATE:
                        begin
                            if (prev_rd_data != sfg_pkg::TILE_FIRE)
                            begin
                                scan_start = 1'b1;
                                state_next = sfg_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sfg_pkg::ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = sfg_pkg::ST_MUL;
                end
            end
            sfg_pkg::ST_MUL:
            begin
                state_next = sfg_pkg::ST_CMP;
            end
            sfg_pkg::ST_CMP:
            begin
                if (ignite)
                begin
                    cur_we    = 1'b1;
                    cur_wdata = sfg_pkg::TILE_FIRE;
                end
                state_next = sfg_pkg::ST_DONE;
            end
            sfg_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = sfg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        snap_wr_addr_reg <= snap_cnt_reg;
        if (accept)
        begin
            op_reg        <= sfg_pkg::op_t'(item.opcode);
            x_reg         <= item.cell_x;
            y_reg         <= item.cell_y;
            tile_reg      <= item.tile_in;
            rn_reg        <= item.rand_near;
            re_reg        <= item.rand_ember;
            snap_cnt_reg  <= '0;
            res_near_reg  <= '0;
            res_ember_reg <= '0;
            res_ign_reg   <= 1'b0;
        end
        if (state_reg == sfg_pkg::ST_SNAP)
        begin
            snap_cnt_reg <= snap_cnt_reg + 1'b1;
        end
        if (state_reg == sfg_pkg::ST_LOOK)
        begin
            res_tile_reg <= look_tile;
            cur_tile_reg <= cur_rd_data;
        end
        if ((state_reg == sfg_pkg::ST_SCAN) && scan_stat.done)
        begin
            res_near_reg  <= scan_near;
            res_ember_reg <= scan_ember;
        end
        if (state_reg == sfg_pkg::ST_MUL)
        begin
            near_prod_reg  <= sfg_pkg::NEAR_PROD_W'(near_chance) *
                              sfg_pkg::NEAR_PROD_W'(res_near_reg);
            ember_prod_reg <= sfg_pkg::EMBER_PROD_W'(ember_chance) *
                              sfg_pkg::EMBER_PROD_W'(res_ember_reg);
        end
        if (state_reg == sfg_pkg::ST_CMP)
        begin
            res_ign_reg  <= ignite;
            res_tile_reg <= ignite ? sfg_pkg::TILE_FIRE : cur_tile_reg;
        end
    end

    assign res.tile_out    = res_tile_reg;
    assign res.near_count  = res_near_reg;
    assign res.ember_count = res_ember_reg;
    assign res.ignited     = res_ign_reg;

endmodule

/* src/stochastic_fire_spread_grid.sv */
// Top level of the fire spread grid: configuration registers, result register, sequencer.
// Depends on sfg_pkg, sfg_if, sfg_ctrl and the assertion macro header.
//
// Usage: items arrive on the item channel (valid/ready); each carries an opcode, a cell
// address, a tile and two uniform random words. Every item produces exactly one transfer
// on the result channel, in order. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at the clock edge; the user must make them only while the block is idle,
// as the block does not enforce it. Steps from item transfer to result valid:
//   write and read: lookup request, lookup, done.
//   snapshot: sweep of all GRID_W*GRID_H cells, one cell copied per cycle through the
//   current-grid read port; then lookup request, lookup, done.
//   update: lookup, then a scan of the N grid cells in the clipped square of half width
//   max(ember_radius, 1) around the cell, multiply and compare; the previous-grid read
//   port serves one window cell per cycle (N = 441 at the reset radius away from edges).
// One item is in work at a time; the next item is taken as soon as the result has moved
// into the output register, even if the receiver has not yet taken it. A stalled
// receiver holds the result there and, once a second result is ready, holds the block.
// Reset loads the registers with their defaults and empties the output register; the
// grid memories are not cleared, so the user must write every cell before it is used.
`timescale 1ns / 1ps
`include "stochastic_fire_spread_grid_macros.svh"

module stochastic_fire_spread_grid #(
    parameter int GRID_W = sfg_pkg::GRID_W_DEF,
    parameter int GRID_H = sfg_pkg::GRID_H_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfg_pkg::CHANCE_W-1:0]    cfg_data,
    sfg_item_if.sink                        item,
    sfg_result_if.source                    result
);

    logic [sfg_pkg::CHANCE_W-1:0] near_chance_reg;
    logic [sfg_pkg::CHANCE_W-1:0] ember_chance_reg;
    logic [sfg_pkg::RADIUS_W-1:0] ember_radius_reg;

    logic             out_valid_reg, out_valid_next;
    sfg_pkg::result_t out_data_reg;

    logic             res_valid;
    logic             res_ready;
    sfg_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_chance_reg  <= sfg_pkg::NEAR_CHANCE_RST;
            ember_chance_reg <= sfg_pkg::EMBER_CHANCE_RST;
            ember_radius_reg <= sfg_pkg::EMBER_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfg_pkg::CFG_NEAR_CHANCE:  near_chance_reg  <= cfg_data;
                sfg_pkg::CFG_EMBER_CHANCE: ember_chance_reg <= cfg_data;
                sfg_pkg::CFG_EMBER_RADIUS: ember_radius_reg <= cfg_data[sfg_pkg::RADIUS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sfg_ctrl #(
        .GRID_W       (GRID_W),
        .GRID_H       (GRID_H)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .near_chance  (near_chance_reg),
        .ember_chance (ember_chance_reg),
        .ember_radius (ember_radius_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // The output register frees the sequencer while the receiver stalls.
    assign res_ready      = !out_valid_reg || result.ready;
    assign out_valid_next = res_valid || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.tile_out    = out_data_reg.tile_out;
    assign result.near_count  = out_data_reg.near_count;
    assign result.ember_count = out_data_reg.ember_count;
    assign result.ignited     = out_data_reg.ignited;

    `SFG_ASSERT_NOW(a_ignite_is_fire, result.valid && result.ignited, result.tile_out == sfg_pkg::TILE_FIRE, "ignited result without a fire tile")
    `SFG_ASSERT_NOW(a_near_bound, result.valid, result.near_count <= sfg_pkg::NEAR_W'(8), "near count above eight")
    `SFG_ASSERT_NOW(a_ember_covers_near, result.valid && (ember_radius_reg != '0), result.ember_count >= sfg_pkg::EMBER_W'(result.near_count), "ember window count below the neighbor count")
    `SFG_ASSERT_NEXT(a_one_item_in_work, item.valid && item.ready, !item.ready, "second item taken while one is in work")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the fire spread grid: loads every cell, walks a directed
// table, then runs random command phases under several register settings.
// Depends on sfg_pkg, the sfg_if channel interfaces and stochastic_fire_spread_grid.

module testbench;

    localparam int GRID_W      = sfg_pkg::GRID_W_DEF;
    localparam int GRID_H      = sfg_pkg::GRID_H_DEF;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 80;
    localparam int PREDICTED   = -1;

    localparam logic [sfg_pkg::TILE_W-1:0]      TILE_GRASS   = 3'd0;
    localparam logic [sfg_pkg::TILE_W-1:0]      TILE_WATER   = 3'd3;
    localparam logic [sfg_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        sfg_pkg::op_t                 op;
        logic [sfg_pkg::COORD_W-1:0]  x;
        logic [sfg_pkg::COORD_W-1:0]  y;
        logic [sfg_pkg::TILE_W-1:0]   tile;
        logic [sfg_pkg::CHANCE_W-1:0] draw_near;
        logic [sfg_pkg::CHANCE_W-1:0] draw_ember;
    } grid_cmd_t;

    typedef struct packed {
        grid_cmd_t        cmd;
        logic             typed;
        sfg_pkg::result_t want;
    } grid_row_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [sfg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [sfg_pkg::CHANCE_W-1:0]    cfg_data  = '0;

    sfg_item_if   item_bus ();
    sfg_result_if result_bus ();

    stochastic_fire_spread_grid i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    // Mirror of the block: live grid, snapshot grid and the three registers.
    logic [sfg_pkg::TILE_W-1:0]   live_tiles   [CELLS];
    logic [sfg_pkg::TILE_W-1:0]   frozen_tiles [CELLS];
    logic [sfg_pkg::CHANCE_W-1:0] near_chance_q  = sfg_pkg::NEAR_CHANCE_RST;
    logic [sfg_pkg::CHANCE_W-1:0] ember_chance_q = sfg_pkg::EMBER_CHANCE_RST;
    logic [sfg_pkg::RADIUS_W-1:0] ember_radius_q = sfg_pkg::EMBER_RADIUS_RST;

    sfg_pkg::result_t awaited_reports [$];
    grid_row_t        directed_rows [$];

    int errors     = 0;
    int burst_left = 0;
    int anchor_x   = 0;
    int anchor_y   = 0;
    int ignitions  = 0;
    int max_near   = 0;
    int max_ember  = 0;
    int op_seen [4];

    always #5 clk = ~clk;

    function automatic int count_fire(int cx, int cy, int rad);
        int n;
        n = 0;
        for (int x = cx - rad; x <= cx + rad; x++)
            for (int y = cy - rad; y <= cy + rad; y++)
                if (x >= 0 && x < GRID_W && y >= 0 && y < GRID_H && !(x == cx && y == cy)
                    && frozen_tiles[y * GRID_W + x] == sfg_pkg::TILE_FIRE)
                    n++;
        return n;
    endfunction

    function automatic sfg_pkg::result_t step_grid(grid_cmd_t c);
        sfg_pkg::result_t r;
        int               idx;
        int               nc;
        int               ec;
        logic [63:0]      near_lim;
        logic [63:0]      ember_lim;
        r   = '0;
        idx = int'(c.y) * GRID_W + int'(c.x);
        case (c.op)
            sfg_pkg::OP_SNAP:
                frozen_tiles = live_tiles;
            sfg_pkg::OP_WRITE:
                if (c.tile <= sfg_pkg::TILE_FIRE)
                    live_tiles[idx] = c.tile;
            sfg_pkg::OP_UPDATE:
            begin
                // A cell already burning in the snapshot is left alone.
                if (frozen_tiles[idx] != sfg_pkg::TILE_FIRE)
                begin
                    nc        = count_fire(c.x, c.y, 1);
                    ec        = count_fire(c.x, c.y, int'(ember_radius_q));
                    near_lim  = 64'(near_chance_q) * 64'(nc);
                    ember_lim = 64'(ember_chance_q) * 64'(ec);
                    r.near_count  = sfg_pkg::NEAR_W'(nc);
                    r.ember_count = sfg_pkg::EMBER_W'(ec);
                    r.ignited     = ({32'd0, c.draw_near} < near_lim)
                                 || ({32'd0, c.draw_ember} < ember_lim);
                    if (r.ignited)
                        live_tiles[idx] = sfg_pkg::TILE_FIRE;
                end
            end
            default:
                ;
        endcase
        r.tile_out = live_tiles[idx];
        return r;
    endfunction

    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 0;
        if (roll < 75)
            return $urandom_range(2, 1);
        if (roll < 93)
            return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    function automatic int pick_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(9) == 0)
        begin
            burst_left = $urandom_range(30, 10);
            return 0;
        end
        return pick_pause();
    endfunction

    function automatic logic [sfg_pkg::COORD_W-1:0] pick_coord(int anchor);
        int v;
        if ($urandom_range(3) == 0)
            return sfg_pkg::COORD_W'($urandom_range(GRID_W - 1));
        v = anchor + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > GRID_W - 1)
            v = GRID_W - 1;
        return sfg_pkg::COORD_W'(v);
    endfunction

    // Random draws cluster around the ignition threshold so both outcomes show up.
    function automatic logic [sfg_pkg::CHANCE_W-1:0] pick_draw(logic [63:0] lim);
        logic [63:0] v;
        case ($urandom_range(3))
            0:
                return $urandom();
            1:
                return sfg_pkg::CHANCE_W'($urandom_range(1023));
            default:
            begin
                v = lim + 64'($urandom_range(2)) - 64'd1;
                if (v > 64'hFFFF_FFFF)
                    v = 64'hFFFF_FFFF;
                return v[sfg_pkg::CHANCE_W-1:0];
            end
        endcase
    endfunction

    function automatic grid_cmd_t random_cmd();
        grid_cmd_t c;
        int        roll;
        c.x          = pick_coord(anchor_x);
        c.y          = pick_coord(anchor_y);
        c.tile       = sfg_pkg::TILE_W'($urandom_range(7));
        c.draw_near  = $urandom();
        c.draw_ember = $urandom();
        roll = $urandom_range(99);
        if (roll < 30)
        begin
            c.op = sfg_pkg::OP_WRITE;
            roll = $urandom_range(99);
            if (roll < 45)
                c.tile = sfg_pkg::TILE_FIRE;
            else if (roll < 90)
                c.tile = sfg_pkg::TILE_W'($urandom_range(3));
        end
        else if (roll < 37)
            c.op = sfg_pkg::OP_SNAP;
        else if (roll < 80)
        begin
            c.op         = sfg_pkg::OP_UPDATE;
            c.draw_near  = pick_draw(64'(near_chance_q) * 64'(count_fire(c.x, c.y, 1)));
            c.draw_ember = pick_draw(64'(ember_chance_q)
                                     * 64'(count_fire(c.x, c.y, int'(ember_radius_q))));
        end
        else
            c.op = sfg_pkg::OP_READ;
        return c;
    endfunction

    function automatic grid_cmd_t make_cmd(sfg_pkg::op_t op, int x, int y,
                                           logic [sfg_pkg::TILE_W-1:0] tile,
                                           logic [sfg_pkg::CHANCE_W-1:0] rn,
                                           logic [sfg_pkg::CHANCE_W-1:0] re);
        grid_cmd_t c;
        c.op         = op;
        c.x          = sfg_pkg::COORD_W'(x);
        c.y          = sfg_pkg::COORD_W'(y);
        c.tile       = tile;
        c.draw_near  = rn;
        c.draw_ember = re;
        return c;
    endfunction

    function automatic void add_row(sfg_pkg::op_t op, int x, int y,
                                    logic [sfg_pkg::TILE_W-1:0] tile,
                                    logic [sfg_pkg::CHANCE_W-1:0] rn,
                                    logic [sfg_pkg::CHANCE_W-1:0] re,
                                    int want_tile);
        grid_row_t row;
        row.cmd           = make_cmd(op, x, y, tile, rn, re);
        row.typed         = (want_tile != PREDICTED);
        row.want          = '0;
        row.want.tile_out = sfg_pkg::TILE_W'(want_tile);
        directed_rows.push_back(row);
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    task automatic send_cmd(input grid_cmd_t c, input logic typed,
                            input sfg_pkg::result_t want);
        int               gap;
        sfg_pkg::result_t r;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.opcode     <= c.op;
        item_bus.cell_x     <= c.x;
        item_bus.cell_y     <= c.y;
        item_bus.tile_in    <= c.tile;
        item_bus.rand_near  <= c.draw_near;
        item_bus.rand_ember <= c.draw_ember;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        r = step_grid(c);
        awaited_reports.push_back(typed ? want : r);
        op_seen[c.op]++;
        ignitions += r.ignited;
        if (r.near_count > max_near)
            max_near = r.near_count;
        if (r.ember_count > max_ember)
            max_ember = r.ember_count;
    endtask

    task automatic drain(input int settle);
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Called at a falling edge; the caller lowers cfg_we after the last write.
    task automatic write_reg(input logic [sfg_pkg::CFG_INDEX_W-1:0] index,
                             input logic [sfg_pkg::CHANCE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            sfg_pkg::CFG_NEAR_CHANCE:  near_chance_q  = data;
            sfg_pkg::CFG_EMBER_CHANCE: ember_chance_q = data;
            sfg_pkg::CFG_EMBER_RADIUS: ember_radius_q = data[sfg_pkg::RADIUS_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
    endtask

    initial
    begin : receiver_pacing
        int hold;
        hold = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if ($urandom_range(2) == 0)
            begin
                result_bus.ready <= 1'b0;
                hold = ($urandom_range(9) != 0) ? $urandom_range(3) : $urandom_range(60, 10);
            end
            else
            begin
                result_bus.ready <= 1'b1;
                hold = ($urandom_range(9) != 0) ? $urandom_range(20)
                                                : $urandom_range(300, 100);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        sfg_pkg::result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, actual tile %0d near %0d "
                         , $time, result_bus.tile_out, result_bus.near_count,
                         "ember %0d ignited %0d", result_bus.ember_count, result_bus.ignited);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                errors += field_diff("tile_out", want.tile_out, result_bus.tile_out)
                        + field_diff("near_count", want.near_count, result_bus.near_count)
                        + field_diff("ember_count", want.ember_count, result_bus.ember_count)
                        + field_diff("ignited", want.ignited, result_bus.ignited);
            end
        end
    end

    initial
    begin : stimulus
        logic [sfg_pkg::CHANCE_W-1:0] near_set   [PHASES];
        logic [sfg_pkg::CHANCE_W-1:0] ember_set  [PHASES];
        logic [sfg_pkg::CHANCE_W-1:0] radius_set [PHASES];
        item_bus.valid      = 1'b0;
        item_bus.opcode     = sfg_pkg::OP_WRITE;
        item_bus.cell_x     = '0;
        item_bus.cell_y     = '0;
        item_bus.tile_in    = '0;
        item_bus.rand_near  = '0;
        item_bus.rand_ember = '0;
        foreach (op_seen[i])
            op_seen[i] = 0;

        near_set[1]   = 32'hFFFF_FFFF;
        ember_set[1]  = 32'h0000_0000;
        radius_set[1] = 32'd1;
        near_set[2]   = 32'h0000_0000;
        ember_set[2]  = 32'hFFFF_FFFF;
        radius_set[2] = 32'd15;
        near_set[3]   = $urandom();
        ember_set[3]  = $urandom();
        radius_set[3] = 32'd0;
        near_set[4]   = $urandom_range(32'h1000_0000);
        ember_set[4]  = $urandom_range(32'h0100_0000);
        // Only the low bits land in the radius register.
        radius_set[4] = ($urandom() & ~32'hF) | 32'($urandom_range(15, 1));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The grid memories come up unknown, so every cell is written first.
        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
                send_cmd(make_cmd(sfg_pkg::OP_WRITE, x, y, sfg_pkg::TILE_W'((x + y) % 4),
                                  $urandom(), $urandom()),
                         1'b0, '0);

        add_row(sfg_pkg::OP_WRITE,   5,  5, sfg_pkg::TILE_FIRE,
                32'h0000_0000, 32'hFFFF_FFFF, sfg_pkg::TILE_FIRE);
        add_row(sfg_pkg::OP_WRITE,   6,  5, sfg_pkg::TILE_FIRE,
                32'hFFFF_FFFF, 32'h0000_0000, sfg_pkg::TILE_FIRE);
        add_row(sfg_pkg::OP_WRITE,   0,  0, sfg_pkg::TILE_FIRE,
                32'h0000_0000, 32'h0000_0000, sfg_pkg::TILE_FIRE);
        add_row(sfg_pkg::OP_WRITE,  31, 31, sfg_pkg::TILE_FIRE,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, sfg_pkg::TILE_FIRE);
        // Tile codes above fire are dropped and the cell keeps its water.
        add_row(sfg_pkg::OP_WRITE,  31,  0, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000, TILE_WATER);
        add_row(sfg_pkg::OP_WRITE,   0, 31, 3'd5, 32'h0000_0000, 32'hFFFF_FFFF, TILE_WATER);
        add_row(sfg_pkg::OP_SNAP,    0,  0, TILE_GRASS,
                32'h0000_0000, 32'h0000_0000, sfg_pkg::TILE_FIRE);
        add_row(sfg_pkg::OP_UPDATE,  5,  5, TILE_GRASS,
                32'h0000_0000, 32'h0000_0000, sfg_pkg::TILE_FIRE);
        add_row(sfg_pkg::OP_UPDATE, 31, 31, 3'd7,
                32'h0000_0000, 32'h0000_0000, sfg_pkg::TILE_FIRE);
        // Two burning neighbors: draw exactly at the threshold, then one below it.
        add_row(sfg_pkg::OP_UPDATE,  6,  6, TILE_GRASS, 32'd85899346, 32'hFFFF_FFFF, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE,  6,  6, TILE_GRASS, 32'd85899345, 32'hFFFF_FFFF, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE, 12,  5, TILE_GRASS, 32'hFFFF_FFFF, 32'd85900, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE, 12,  5, TILE_GRASS, 32'hFFFF_FFFF, 32'd85899, PREDICTED);
        // Fire in the live grid only; a passing test still reports an ignition.
        add_row(sfg_pkg::OP_WRITE,  10, 10, sfg_pkg::TILE_FIRE,
                32'h0000_0000, 32'h0000_0000, sfg_pkg::TILE_FIRE);
        add_row(sfg_pkg::OP_UPDATE, 10, 10, TILE_GRASS, 32'hFFFF_FFFF, 32'h0000_0000, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE,  0,  1, TILE_GRASS, 32'h0000_0000, 32'hFFFF_FFFF, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE, 31, 30, TILE_GRASS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICTED);
        add_row(sfg_pkg::OP_READ,   31,  0, TILE_GRASS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TILE_WATER);
        add_row(sfg_pkg::OP_READ,    0, 31, 3'd7,       32'h0000_0000, 32'h0000_0000, TILE_WATER);
        add_row(sfg_pkg::OP_READ,    6,  6, TILE_GRASS, 32'h0000_0000, 32'h0000_0000, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE, 15, 15, 3'd2,       32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICTED);
        add_row(sfg_pkg::OP_SNAP,   16, 16, TILE_GRASS, 32'h0000_0000, 32'h0000_0000, PREDICTED);
        add_row(sfg_pkg::OP_UPDATE, 16, 16, TILE_GRASS, 32'h0000_0000, 32'h0000_0000, PREDICTED);
        add_row(sfg_pkg::OP_READ,   16, 16, TILE_GRASS, 32'hFFFF_FFFF, 32'h0000_0000, PREDICTED);
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        // Phase zero keeps the reset settings; the others rewrite every register.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain(3);
                write_reg(sfg_pkg::CFG_NEAR_CHANCE, near_set[p]);
                write_reg(sfg_pkg::CFG_EMBER_CHANCE, ember_set[p]);
                if (p == 3)
                    write_reg(CFG_UNMAPPED, $urandom());
                write_reg(sfg_pkg::CFG_EMBER_RADIUS, radius_set[p]);
                cfg_we <= 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 16 == 0)
                begin
                    anchor_x = ($urandom_range(2) == 0) ? ($urandom_range(1) ? GRID_W - 1 : 0)
                                                        : $urandom_range(GRID_W - 1);
                    anchor_y = ($urandom_range(2) == 0) ? ($urandom_range(1) ? GRID_H - 1 : 0)
                                                        : $urandom_range(GRID_H - 1);
                end
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        drain(30);
        $display("covered %0d writes, %0d snapshots, %0d updates and %0d reads over %0d settings",
                 op_seen[sfg_pkg::OP_WRITE], op_seen[sfg_pkg::OP_SNAP],
                 op_seen[sfg_pkg::OP_UPDATE], op_seen[sfg_pkg::OP_READ], PHASES);
        $display("updates lit %0d cells; peak neighbor count %0d, peak ember count %0d",
                 ignitions, max_near, max_ember);
        if (errors == 0)
            $display("stochastic_fire_spread_grid regression: pass");
        else
            $display("stochastic_fire_spread_grid regression: fail");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("stochastic_fire_spread_grid regression: fail");
        $finish;
    end

endmodule
